// ===== rtl/prefix_expression_stack_evaluator_macros.svh =====
// Assertion macros shared by the evaluator RTL.
// Included by files that carry concurrent assertions; no dependencies.
`ifndef PREFIX_EXPRESSION_STACK_EVALUATOR_MACROS_SVH
`define PREFIX_EXPRESSION_STACK_EVALUATOR_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PESE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define PESE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/pese_pkg.sv =====
// Package of the prefix expression evaluator: token and status codes, types, saturation.
// No dependencies.
package pese_pkg;
    localparam int unsigned STACK_DEPTH_DEF = 64;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned VAL_W = 32;

    localparam logic [2:0] TOK_OPERAND = 3'd0;
    localparam logic [2:0] TOK_ADD     = 3'd1;
    localparam logic [2:0] TOK_SUB     = 3'd2;
    localparam logic [2:0] TOK_MUL     = 3'd3;
    localparam logic [2:0] TOK_DIV     = 3'd4;
    localparam logic [2:0] TOK_INVALID = 3'd5;
    localparam logic [2:0] TOK_RSVD6   = 3'd6;
    localparam logic [2:0] TOK_RSVD7   = 3'd7;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_LEFTOVER = 3'd2;
    localparam logic [2:0] ST_MISSING  = 3'd3;
    localparam logic [2:0] ST_DIVZERO  = 3'd4;
    localparam logic [2:0] ST_INVALID  = 3'd5;
    localparam logic [2:0] ST_OVERFLOW = 3'd6;

    typedef enum logic [2:0] {
        K_PUSH = 3'd0, K_ADD = 3'd1, K_SUB = 3'd2, K_MUL = 3'd3, K_DIV = 3'd4,
        K_BAD = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic              last;
        logic signed [31:0] value;
    } t_cmd;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        begin
            hi = 66'sd2147483647;
            lo = -66'sd2147483648;
            if (x > hi) sat32 = 32'sh7fffffff;
            else if (x < lo) sat32 = 32'sh80000000;
            else sat32 = x[31:0];
        end
    endfunction
endpackage

// ===== rtl/prefix_expression_stack_evaluator.sv =====
// Prefix expression evaluator, Q16.16. A request is registered in the queue before the
// back end takes it. From idle the back end goes to write on an operand, to report on a
// skipped token; add and subtract read, read, calculate, write; multiply adds a multiply
// state, divide runs a 64-step divider, an arithmetic-stage error goes to report. The last
// token adds a report state. A four-entry queue absorbs requests; a held report stalls the
// back end. Synchronous active-low reset empties the stack, queue and error latch.
module prefix_expression_stack_evaluator #(
    parameter int unsigned STACK_DEPTH = pese_pkg::STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // operand_value[31:0]
    input  logic [2:0]  s_axis_tuser,   // req_type[2:0]
    input  logic        s_axis_tlast,   // last_token
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // final_value[31:0]
    output logic [2:0]  m_axis_tuser    // status_code[2:0]
);
    pese_pkg::t_cmd cmd;
    logic cmd_valid, cmd_take;
    logic [31:0] fv;
    logic [2:0] sc;

    pese_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready), .i_req_type(s_axis_tuser),
        .i_operand_value(s_axis_tdata), .i_last_token(s_axis_tlast),
        .o_cmd_valid(cmd_valid), .i_cmd_take(cmd_take), .o_cmd(cmd)
    );

    pese_exec #(.STACK_DEPTH(STACK_DEPTH)) u_exec (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(cmd_valid),
        .o_cmd_take(cmd_take), .i_cmd(cmd), .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready), .o_final_value(fv), .o_status_code(sc)
    );

    assign m_axis_tdata = fv;
    assign m_axis_tuser = sc;
endmodule

// ===== rtl/pese_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module pese_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== rtl/pese_front.sv =====
// Front end: classifies tokens and queues them for the execution unit.
// Depends on pese_pkg.
module pese_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0]           i_req_type,
    input  logic [31:0]          i_operand_value,
    input  logic                 i_last_token,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_take,
    output pese_pkg::t_cmd       o_cmd
);
    localparam int unsigned QD = pese_pkg::QUEUE_DEPTH;
    localparam int unsigned QA = $clog2(QD);
    pese_pkg::t_cmd r_q [QD];
    logic [QA-1:0] r_wp, r_rp;
    logic [QA:0]   r_cnt;
    pese_pkg::t_cmd cls;
    logic push, pop;

    always_comb begin
        cls.last  = i_last_token;
        cls.value = i_operand_value;
        case (i_req_type)
            pese_pkg::TOK_OPERAND: cls.kind = pese_pkg::K_PUSH;
            pese_pkg::TOK_ADD:     cls.kind = pese_pkg::K_ADD;
            pese_pkg::TOK_SUB:     cls.kind = pese_pkg::K_SUB;
            pese_pkg::TOK_MUL:     cls.kind = pese_pkg::K_MUL;
            pese_pkg::TOK_DIV:     cls.kind = pese_pkg::K_DIV;
            default:               cls.kind = pese_pkg::K_BAD;
        endcase
    end

    assign o_ready     = (r_cnt != (QA+1)'(QD));
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = o_cmd_valid && i_cmd_take;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= cls;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QA+1)'(push) - (QA+1)'(pop);
        end
    end
endmodule

// ===== rtl/pese_exec.sv =====
// Execution unit: stack in RAM, arithmetic, serial divider, report.
// Depends on pese_pkg, pese_ram and the assertion macro header.
`include "prefix_expression_stack_evaluator_macros.svh"
module pese_exec #(
    parameter int unsigned STACK_DEPTH = pese_pkg::STACK_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_take,
    input  pese_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [31:0]    o_final_value,
    output logic [2:0]     o_status_code
);
    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001, S_RDA = 8'b00000010, S_RDB = 8'b00000100,
        S_CALC = 8'b00001000, S_MUL = 8'b00010000, S_DIV = 8'b00100000,
        S_WR   = 8'b01000000, S_REP = 8'b10000000
    } t_state;

    t_state r_st, n_st;
    logic [CW-1:0] r_cnt;
    logic [2:0] r_err;
    pese_pkg::t_cmd r_cmd;
    logic signed [31:0] r_a, r_res, r_top;
    logic signed [63:0] r_prod;
    logic [63:0] r_rem, r_quo;
    logic [31:0] r_den;
    logic [5:0] r_it;
    logic r_neg;
    logic r_ov;
    logic [31:0] rdata;
    logic we;
    logic [AW-1:0] addr;
    logic [64:0] trial;
    logic signed [65:0] mul_round;
    logic signed [65:0] div_quo;

    pese_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_addr(addr), .i_wdata(r_res), .o_rdata(rdata)
    );

    assign o_cmd_take = (r_st == S_IDLE) && !r_ov;
    assign trial = {r_rem[63:0], r_quo[63]} - {33'd0, r_den};

    // Truncate toward zero: bias negative products before the shift.
    assign mul_round = (66'(r_prod) + (r_prod[63] ? 66'sd65535 : 66'sd0)) >>> 16;
    assign div_quo = r_neg ? -66'($signed({1'b0, r_quo[62:0], !trial[64]}))
                           : 66'($signed({1'b0, r_quo[62:0], !trial[64]}));

    always_comb begin
        we = 1'b0;
        addr = r_cnt[AW-1:0];
        case (r_st)
            S_IDLE: addr = AW'(r_cnt - CW'(1));
            S_RDA, S_RDB: addr = AW'(r_cnt - CW'(2));
            S_WR: begin
                we = 1'b1;
                addr = (r_cmd.kind == pese_pkg::K_PUSH) ? r_cnt[AW-1:0]
                                                       : AW'(r_cnt - CW'(2));
            end
            default: addr = r_cnt[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cnt <= '0; r_err <= pese_pkg::ST_OK; r_ov <= 1'b0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: if (i_cmd_valid && !r_ov) begin
                    r_cmd <= i_cmd;
                    r_res <= i_cmd.value;
                    if (r_err != pese_pkg::ST_OK) r_st <= S_REP;
                    else if (i_cmd.kind == pese_pkg::K_PUSH) begin
                        if (r_cnt >= CW'(STACK_DEPTH)) begin
                            r_err <= pese_pkg::ST_OVERFLOW; r_st <= S_REP;
                        end else r_st <= S_WR;
                    end else if (r_cnt < CW'(2)) begin
                        r_err <= pese_pkg::ST_MISSING; r_st <= S_REP;
                    end else r_st <= S_RDA;
                end
                // The top entry was read while idle; the second one is read now.
                S_RDA: begin r_a <= rdata; r_st <= S_RDB; end
                S_RDB: r_st <= S_CALC;
                S_CALC: begin
                    r_st <= S_WR;
                    case (r_cmd.kind)
                        pese_pkg::K_ADD: r_res <= pese_pkg::sat32(66'(r_a) + 66'(signed'(rdata)));
                        pese_pkg::K_SUB: r_res <= pese_pkg::sat32(66'(r_a) - 66'(signed'(rdata)));
                        pese_pkg::K_MUL: begin
                            r_prod <= r_a * signed'(rdata); r_st <= S_MUL;
                        end
                        pese_pkg::K_DIV: begin
                            if (rdata == '0) begin
                                r_err <= pese_pkg::ST_DIVZERO; r_st <= S_REP;
                            end else begin
                                r_neg <= r_a[31] ^ rdata[31];
                                r_quo <= {16'd0, (r_a[31] ? 32'(-r_a) : 32'(r_a)), 16'd0};
                                r_den <= rdata[31] ? 32'(-signed'(rdata)) : rdata;
                                r_rem <= '0; r_it <= '0; r_st <= S_DIV;
                            end
                        end
                        default: begin r_err <= pese_pkg::ST_INVALID; r_st <= S_REP; end
                    endcase
                end
                S_MUL: begin
                    r_res <= pese_pkg::sat32(mul_round);
                    r_st <= S_WR;
                end
                S_DIV: begin
                    // Restoring divider, one quotient bit per cycle.
                    if (!trial[64]) r_rem <= trial[63:0];
                    else r_rem <= {r_rem[62:0], r_quo[63]};
                    r_quo <= {r_quo[62:0], !trial[64]};
                    r_it <= r_it + 6'd1;
                    if (r_it == 6'd63) r_st <= S_WR;
                end
                S_WR: begin
                    r_cnt <= (r_cmd.kind == pese_pkg::K_PUSH) ? r_cnt + CW'(1)
                                                             : r_cnt - CW'(1);
                    r_st <= r_cmd.last ? S_REP : S_IDLE;
                end
                S_REP: begin
                    if (r_cmd.last) begin
                        r_ov <= 1'b1;
                        r_cnt <= '0; r_err <= pese_pkg::ST_OK;
                        o_final_value <= '0;
                        if (r_err != pese_pkg::ST_OK) o_status_code <= r_err;
                        else if (r_cnt == '0) o_status_code <= pese_pkg::ST_EMPTY;
                        else if (r_cnt != CW'(1)) o_status_code <= pese_pkg::ST_LEFTOVER;
                        else begin
                            o_status_code <= pese_pkg::ST_OK;
                            o_final_value <= r_top;
                        end
                    end
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
            if (r_st == S_DIV && r_it == 6'd63) begin
                if (r_quo[63] && !r_neg) r_res <= 32'sh7fffffff;
                else r_res <= pese_pkg::sat32(div_quo);
            end
        end
    end

    // Bottom entry, kept aside so the report needs no RAM read.
    always_ff @(posedge i_clk) begin
        if (r_st == S_WR && addr == '0) r_top <= r_res;
    end

    assign o_valid = r_ov;

    `PESE_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(STACK_DEPTH))
    `PESE_ASSERT_IMP(a_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_st))
    `PESE_ASSERT_NEXT(a_clear, i_clk, i_rst_n, r_st == S_REP && r_cmd.last, r_cnt == '0)
endmodule
